// ===== rtl/core/hot_page_migration_policy_defines.svh =====
// Assertion macros for the hot page migration policy block
`ifndef HOT_PAGE_MIGRATION_POLICY_DEFINES_SVH
`define HOT_PAGE_MIGRATION_POLICY_DEFINES_SVH

`ifndef SYNTH
`define HPM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpm assertion failed");
`define HPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpm assertion failed");
`else
`define HPM_ASSERT_IMP(lbl, ante, cons)
`define HPM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/hpm_pkg.sv =====
// Shared types and constants for the hot page migration policy block
`timescale 1ns / 1ps
`default_nettype none
package hpm_pkg;
    localparam int DEF_PAGES       = 256;
    localparam int DEF_SLOTS       = 64;
    localparam int DEF_OFFSET_BITS = 12;

    localparam int PAGE_NUM_W = 8;
    localparam int SLOT_NUM_W = 6;
    localparam int OFFSET_W   = 12;
    localparam int COUNT_W    = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic REQ_ACCESS  = 1'b0;
    localparam logic REQ_REFRESH = 1'b1;
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic                  is_refresh;
        logic                  in_range;
        logic [PAGE_NUM_W-1:0] page;
        logic [SLOT_NUM_W-1:0] slot;
        logic [OFFSET_W-1:0]   offset;
    } hpm_req_t;

    typedef struct packed {
        logic     valid;
        hpm_req_t req;
    } hpm_qhead_t;

    typedef struct packed {
        logic clearing;
    } hpm_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_WR,
        ST_R_SLOT,
        ST_R_RD,
        ST_R_CMP,
        ST_R_REPORT
    } hpm_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/hot_page_migration_policy.sv =====
// Top level of the hot page migration policy block
`timescale 1ns / 1ps
`default_nettype none
// Counts accesses per slow-memory page and places the hottest page of each
// group (page mod SLOTS) in its fast slot. An access transaction passes
// through dispatch, counter read, and counter write and reply, and returns
// one reply; a refresh transaction walks every slot, reading and clearing
// each counter of the slot's group (a read step and a compare-and-clear
// step per page), and returns SLOTS reports, the last marked by tlast.
// The counter memory has a single read port. A two-entry queue lets
// requests be taken while the engine works. After reset the counter
// memory is cleared, one entry a cycle; s_tready stays low during that pass.
module hot_page_migration_policy #(
    parameter int PAGES       = hpm_pkg::DEF_PAGES,
    parameter int SLOTS       = hpm_pkg::DEF_SLOTS,
    parameter int OFFSET_BITS = hpm_pkg::DEF_OFFSET_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // page_number, page_offset, zero pad
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // hit, slot, offset_out, moved, evicted_valid,
                                        // evicted_page, loaded_page, zero pad
    output logic             m_tuser,   // report_kind
    output logic             m_tlast
);
    import hpm_pkg::*;

    hpm_status_t status;
    hpm_qhead_t  head;
    logic        pop;

    hpm_front #(
        .PAGES(PAGES),
        .SLOTS(SLOTS),
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .status(status),
        .head(head),
        .pop(pop)
    );

    hpm_back #(
        .PAGES(PAGES),
        .SLOTS(SLOTS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .pop(pop),
        .status(status),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );
endmodule
`default_nettype wire

// ===== rtl/core/hpm_front.sv =====
// Front end: accepts requests, classifies them and queues them for the engine
`timescale 1ns / 1ps
`default_nettype none
module hpm_front #(
    parameter int PAGES       = hpm_pkg::DEF_PAGES,
    parameter int SLOTS       = hpm_pkg::DEF_SLOTS,
    parameter int OFFSET_BITS = hpm_pkg::DEF_OFFSET_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [23:0]         s_tdata,   // page_number, page_offset, zero pad
    input  wire logic                s_tuser,   // req_type
    input  wire hpm_pkg::hpm_status_t status,
    output hpm_pkg::hpm_qhead_t      head,
    input  wire logic                pop
);
    import hpm_pkg::*;

    localparam logic [OFFSET_W-1:0] OFF_MASK =
        (OFFSET_BITS >= OFFSET_W) ? '1 : OFFSET_W'((1 << OFFSET_BITS) - 1);

    function automatic logic [SLOT_NUM_W-1:0] slot_of(input logic [PAGE_NUM_W-1:0] pg);
        logic [SLOT_NUM_W:0] r;
        begin
            r = '0;
            for (int i = PAGE_NUM_W - 1; i >= 0; i--)
            begin
                r = {r[SLOT_NUM_W-1:0], pg[i]};
                if (r >= (SLOT_NUM_W + 1)'(SLOTS))
                begin
                    r = r - (SLOT_NUM_W + 1)'(SLOTS);
                end
            end
            return r[SLOT_NUM_W-1:0];
        end
    endfunction

    hpm_req_t    entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    hpm_req_t    in_req;
    logic        push;

    always_comb
    begin
        in_req.is_refresh = (s_tuser == REQ_REFRESH);
        in_req.page       = s_tdata[7:0];
        in_req.offset     = s_tdata[19:8] & OFF_MASK;
        in_req.in_range   = (13'(s_tdata[7:0]) < 13'(PAGES));
        in_req.slot       = slot_of(s_tdata[7:0]);
    end

    assign s_tready = !status.clearing && (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_req;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.req   = entry_reg[rd_ptr_reg];
endmodule
`default_nettype wire

// ===== rtl/core/hpm_back.sv =====
// Back end: counter memory, slot table and the access / refresh sequencer
`timescale 1ns / 1ps
`default_nettype none
`include "hot_page_migration_policy_defines.svh"
module hpm_back #(
    parameter int PAGES = hpm_pkg::DEF_PAGES,
    parameter int SLOTS = hpm_pkg::DEF_SLOTS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire hpm_pkg::hpm_qhead_t head,
    output logic                     pop,
    output hpm_pkg::hpm_status_t     status,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,  // hit, slot, offset_out, moved,
                                               // evicted_valid, evicted_page,
                                               // loaded_page, zero pad
    output logic                     m_tuser,  // report_kind
    output logic                     m_tlast
);
    import hpm_pkg::*;

    localparam int PAGE_W = $clog2(PAGES);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW     = $clog2(PAGES + SLOTS + 1);

    logic [COUNT_W-1:0] cnt_mem [PAGES];
    logic [PAGE_W-1:0]  sp_mem  [SLOTS];
    logic [COUNT_W-1:0] cnt_rd_reg;
    logic [PAGE_W-1:0]  sp_rd_reg;

    logic               cnt_we, cnt_re;
    logic [PAGE_W-1:0]  cnt_waddr, cnt_raddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               sp_we, sp_re;
    logic [SLOT_W-1:0]  sp_addr;
    logic [PAGE_W-1:0]  sp_wdata;

    hpm_state_t         state_reg, state_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [SLOT_W-1:0]  s_reg, s_next;
    logic [PAGE_W-1:0]  best_reg, best_next;
    logic [COUNT_W-1:0] bestn_reg, bestn_next;
    logic               found_reg, found_next;
    logic [SLOTS-1:0]   slot_valid_reg, slot_valid_next;

    logic               out_valid_reg, out_valid_next;
    logic [36:0]        out_data_reg, out_data_next;
    logic               out_kind_reg, out_kind_next;
    logic               out_last_reg, out_last_next;

    logic               emit, emit_ok, last_slot, sv, resident;
    logic [SLOT_W-1:0]  acc_slot;
    logic [PAGE_W-1:0]  acc_page;

    assign emit_ok   = !out_valid_reg || m_tready;
    assign acc_slot  = SLOT_W'(head.req.slot);
    assign acc_page  = PAGE_W'(head.req.page);
    assign last_slot = (s_reg == SLOT_W'(SLOTS - 1));
    assign sv        = slot_valid_reg[s_reg];
    assign resident  = sv && (sp_rd_reg == best_reg);

    always_comb
    begin
        state_next      = state_reg;
        p_next          = p_reg;
        s_next          = s_reg;
        best_next       = best_reg;
        bestn_next      = bestn_reg;
        found_next      = found_reg;
        slot_valid_next = slot_valid_reg;
        cnt_we = 1'b0; cnt_re = 1'b0;
        cnt_waddr = p_reg[PAGE_W-1:0]; cnt_raddr = p_reg[PAGE_W-1:0];
        cnt_wdata = '0;
        sp_we = 1'b0; sp_re = 1'b0; sp_addr = s_reg; sp_wdata = best_reg;
        pop = 1'b0;
        emit = 1'b0;
        out_data_next = out_data_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_we = 1'b1;
                if (p_reg == PW'(PAGES - 1))
                begin
                    p_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    p_next = p_reg + PW'(1);
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    s_next     = '0;
                    state_next = head.req.is_refresh ? ST_R_SLOT : ST_A_RD;
                end
            end
            ST_A_RD:
            begin
                cnt_re     = head.req.in_range;
                cnt_raddr  = acc_page;
                sp_re      = 1'b1;
                sp_addr    = acc_slot;
                state_next = ST_A_WR;
            end
            ST_A_WR:
            begin
                cnt_waddr = acc_page;
                cnt_wdata = cnt_rd_reg + COUNT_W'(1);
                if (emit_ok)
                begin
                    cnt_we = head.req.in_range && (cnt_rd_reg != COUNT_MAX);
                    emit   = 1'b1;
                    out_kind_next = KIND_ACCESS;
                    out_last_next = 1'b1;
                    out_data_next = {8'd0, 8'd0, 1'b0, 1'b0, head.req.offset,
                                     head.req.slot,
                                     head.req.in_range && slot_valid_reg[acc_slot]
                                     && (sp_rd_reg == acc_page)};
                    pop        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_R_SLOT:
            begin
                sp_re      = 1'b1;
                found_next = 1'b0;
                p_next     = PW'(s_reg);
                state_next = (PW'(s_reg) < PW'(PAGES)) ? ST_R_RD : ST_R_REPORT;
            end
            ST_R_RD:
            begin
                cnt_re     = 1'b1;
                state_next = ST_R_CMP;
            end
            ST_R_CMP:
            begin
                if (!found_reg || (cnt_rd_reg > bestn_reg))
                begin
                    bestn_next = cnt_rd_reg;
                    best_next  = p_reg[PAGE_W-1:0];
                    found_next = 1'b1;
                end
                cnt_we     = 1'b1;
                p_next     = p_reg + PW'(SLOTS);
                state_next = (p_next < PW'(PAGES)) ? ST_R_RD : ST_R_REPORT;
            end
            ST_R_REPORT:
            begin
                if (emit_ok)
                begin
                    emit = 1'b1;
                    out_kind_next = KIND_REPORT;
                    out_last_next = last_slot;
                    if (found_reg && !resident)
                    begin
                        sp_we = 1'b1;
                        slot_valid_next[s_reg] = 1'b1;
                        out_data_next = {8'(best_reg), sv ? 8'(sp_rd_reg) : 8'd0, sv,
                                         1'b1, 12'd0, 6'(s_reg), 1'b0};
                    end
                    else
                    begin
                        out_data_next = {found_reg ? 8'(best_reg)
                                                   : (sv ? 8'(sp_rd_reg) : 8'd0),
                                         8'd0, 1'b0, 1'b0, 12'd0, 6'(s_reg), 1'b0};
                    end
                    if (last_slot)
                    begin
                        pop        = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        s_next     = s_reg + SLOT_W'(1);
                        state_next = ST_R_SLOT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            p_reg          <= '0;
            s_reg          <= '0;
            found_reg      <= 1'b0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            p_reg          <= p_next;
            s_reg          <= s_next;
            found_reg      <= found_next;
            slot_valid_reg <= slot_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        bestn_reg    <= bestn_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sp_we)
        begin
            sp_mem[sp_addr] <= sp_wdata;
        end
        if (sp_re)
        begin
            sp_rd_reg <= sp_mem[sp_addr];
        end
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    `HPM_ASSERT_IMP(a_no_pop_while_clearing, state_reg == ST_CLEAR, !pop)
    `HPM_ASSERT_IMP(a_no_overwrite, emit, !out_valid_reg || m_tready)
    `HPM_ASSERT_NEXT(a_refresh_ends_idle,
        state_reg == ST_R_REPORT && emit && last_slot, state_reg == ST_IDLE)
endmodule
`default_nettype wire
